/* rtl/str_pkg.sv */
// Shared constants, register indexes and the logistic table helper for transmitter release.
`timescale 1ns / 1ps

package str_pkg;

    // Field and port widths fixed by the interface
    localparam int VOLT_W     = 16;
    localparam int OUT_CONC_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SLOPE_W    = 15;
    localparam int FACTOR_W   = 16;
    localparam int TICK_W     = 16;
    localparam int ENTRY_W    = 17;   // logistic entry, Q0.16 up to and including 1.0

    // Parameter defaults
    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_CONC_BITS     = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_V    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_V   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VESICLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACT   = 3'd7;

    // Register reset values
    localparam logic                  RST_MODE     = 1'b1;
    localparam logic [23:0]           RST_PEAK     = 24'hFFFFFF;
    localparam logic [VOLT_W-1:0]     RST_HALF_V   = 16'h0000;
    localparam logic [SLOPE_W-1:0]    RST_SLOPE_V  = 15'd256;
    localparam logic [FACTOR_W-1:0]   RST_DECAY    = 16'd655;
    localparam logic [23:0]           RST_BASELINE = 24'h000000;
    localparam logic [23:0]           RST_VESICLE  = 24'h000000;
    localparam logic [TICK_W-1:0]     RST_REFRACT  = 16'h0000;

    localparam logic                  MODE_SIGMOID = 1'b0;

    localparam longint unsigned Q32_ONE = 64'd1 << 32;
    localparam longint unsigned Q48_ONE = 64'd1 << 48;

    // e^(-256*r) in Q32: six Taylor terms on r, then square eight times with rounding.
    // Used only at elaboration to build the logistic table.
    function automatic longint unsigned exp_neg_q32(input longint unsigned r);
        longint unsigned sum;
        longint unsigned term;
        sum  = Q32_ONE;
        term = Q32_ONE;
        term = ((term * r) >> 32) / 1;
        sum  = sum - term;
        term = ((term * r) >> 32) / 2;
        sum  = sum + term;
        term = ((term * r) >> 32) / 3;
        sum  = sum - term;
        term = ((term * r) >> 32) / 4;
        sum  = sum + term;
        term = ((term * r) >> 32) / 5;
        sum  = sum - term;
        term = ((term * r) >> 32) / 6;
        sum  = sum + term;
        for (int k = 0; k < 8; k++) begin
            sum = (sum * sum + (64'd1 << 31)) >> 32;
        end
        return sum;
    endfunction

endpackage

/* rtl/synaptic_transmitter_release.sv */
// Transmitter release top level: registers, release decision, shared multiplier and sequencer.
//
//  channel  direction  handshake         payload
//  s_       in         s_valid/s_ready   s_voltage (Q8.8 mV, signed)
//  m_       out        m_valid/m_ready   m_concentration (Q8.16), m_released
//  cfg_     in         cfg_we            cfg_index, cfg_data
//
// A decay tick goes from acceptance through ST_MUL and ST_FIN to m_valid; a sigmoid tick
// (mode 0 or a release) first passes ST_DIV, where the index divider makes one bit per
// cycle, and ST_TAB. One word is in flight; s_ready is high only in idle.
// A finished word waits in the output register, and the next word is taken meanwhile.
// Reset is synchronous, active low: registers go to their defaults, concentration to 0.
`timescale 1ns / 1ps

module synaptic_transmitter_release #(
    parameter int SIGMOID_TABLE_ENTRIES = str_pkg::DEF_TABLE_ENTRIES,
    parameter int CONC_BITS             = str_pkg::DEF_CONC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [str_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [str_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [str_pkg::VOLT_W-1:0]   s_voltage,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [str_pkg::OUT_CONC_W-1:0]      m_concentration,
    output logic                                m_released
);

    localparam int IDXW  = $clog2(SIGMOID_TABLE_ENTRIES);
    localparam int CB    = CONC_BITS;
    localparam int WIDE  = (CB > str_pkg::OUT_CONC_W) ? CB : str_pkg::OUT_CONC_W;
    localparam int EW    = str_pkg::ENTRY_W;
    localparam int PW    = CB + EW;
    localparam logic [WIDE-1:0] CONC_MAX_W = WIDE'({CB{1'b1}});
    localparam logic [WIDE-1:0] OUT_MAX_W  = WIDE'({str_pkg::OUT_CONC_W{1'b1}});
    localparam logic [str_pkg::TICK_W-1:0] TICK_SAT = '1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_TAB  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // Logistic table, built at elaboration
    logic [EW-1:0] sig_table [SIGMOID_TABLE_ENTRIES];

    for (genvar g = 0; g < SIGMOID_TABLE_ENTRIES; g++) begin : g_table
        localparam longint C_G = 2 * longint'(g) - longint'(SIGMOID_TABLE_ENTRIES) + 1;
        localparam longint unsigned M_G = (C_G < 0) ? longint'(-C_G) : longint'(C_G);
        localparam longint unsigned R_G = (M_G << 27) / SIGMOID_TABLE_ENTRIES;
        localparam longint unsigned E_G = str_pkg::exp_neg_q32(R_G);
        localparam longint unsigned D_G = str_pkg::Q32_ONE + E_G;
        localparam longint unsigned S_G = (str_pkg::Q48_ONE + D_G / 2) / D_G;
        localparam longint unsigned V_G = (C_G < 0) ? (64'd65536 - S_G) : S_G;
        assign sig_table[g] = EW'(V_G);
    end

    // Configuration registers
    logic                          mode_reg;
    logic [23:0]                   peak_reg;
    logic [str_pkg::VOLT_W-1:0]    half_v_reg;
    logic [str_pkg::SLOPE_W-1:0]   slope_v_reg;
    logic [str_pkg::FACTOR_W-1:0]  decay_reg;
    logic [23:0]                   baseline_reg;
    logic [23:0]                   vesicle_reg;
    logic [str_pkg::TICK_W-1:0]    refract_reg;

    // Tick state
    logic [CB-1:0]                 conc_reg;
    logic                          armed_reg;
    logic [str_pkg::TICK_W-1:0]    tsr_reg;

    // Sequencer and datapath
    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic                          rel_reg;
    logic                          sig_path_reg;
    logic                          down_reg;
    logic [CB-1:0]                 op_a_reg;
    logic [EW-1:0]                 op_b_reg;
    logic [PW-1:0]                 prod_reg;
    logic                          m_valid_reg;
    logic [str_pkg::OUT_CONC_W-1:0] m_conc_reg;
    logic                          m_rel_reg;

    logic                          accept;
    logic                          fin_fire;
    logic                          v_neg;
    logic                          v_pos;
    logic [str_pkg::TICK_W-1:0]    tsr_inc;
    logic                          rel_now;
    logic                          sig_need;
    logic [CB-1:0]                 base_c;
    logic [CB-1:0]                 peak_c;
    logic [CB-1:0]                 mag;
    logic signed [str_pkg::VOLT_W:0] diff;
    logic                          div_done;
    logic [IDXW-1:0]               div_idx;
    logic [PW:0]                   rounded;
    logic [CB-1:0]                 scaled;
    logic [WIDE:0]                 ves_sum;
    logic [CB-1:0]                 conc_next;
    logic [WIDE-1:0]               conc_wide;

    function automatic logic [CB-1:0] clamp24(input logic [23:0] x);
        logic [WIDE-1:0] w;
        w = WIDE'(x);
        return (w > CONC_MAX_W) ? CB'(CONC_MAX_W) : CB'(w);
    endfunction

    assign base_c = clamp24(baseline_reg);
    assign peak_c = clamp24(peak_reg);

    assign accept   = s_valid && s_ready;
    assign fin_fire = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    assign v_neg    = s_voltage[str_pkg::VOLT_W-1];
    assign v_pos    = !v_neg && (s_voltage != '0);
    assign tsr_inc  = (tsr_reg == TICK_SAT) ? tsr_reg : tsr_reg + 1'b1;
    assign rel_now  = v_pos && armed_reg && (tsr_inc >= refract_reg);
    assign sig_need = (mode_reg == str_pkg::MODE_SIGMOID) || rel_now;
    assign mag      = (conc_reg > base_c) ? conc_reg - base_c : base_c - conc_reg;
    assign diff     = (str_pkg::VOLT_W+1)'(s_voltage) - (str_pkg::VOLT_W+1)'(signed'(half_v_reg));

    str_idx_div #(
        .TABLE_ENTRIES (SIGMOID_TABLE_ENTRIES)
    ) u_idx_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && sig_need),
        .diff    (diff),
        .slope   (slope_v_reg),
        .done    (div_done),
        .idx     (div_idx)
    );

    // Round the Q16 product back to concentration units
    assign rounded = (PW+1)'(prod_reg) + (PW+1)'(32768);
    assign scaled  = rounded[CB+15:16];
    assign ves_sum = (WIDE+1)'(scaled) + (WIDE+1)'(vesicle_reg);

    always_comb begin
        if (!sig_path_reg) begin
            conc_next = down_reg ? conc_reg - scaled : conc_reg + scaled;
        end else if (rel_reg && (mode_reg != str_pkg::MODE_SIGMOID)) begin
            conc_next = (ves_sum > (WIDE+1)'(CONC_MAX_W)) ? CB'(CONC_MAX_W) : CB'(ves_sum);
        end else begin
            conc_next = scaled;
        end
    end

    assign conc_wide = WIDE'(conc_next);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = sig_need ? ST_DIV : ST_MUL;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_TAB;
                end
            end
            ST_TAB:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= str_pkg::RST_MODE;
            peak_reg     <= str_pkg::RST_PEAK;
            half_v_reg   <= str_pkg::RST_HALF_V;
            slope_v_reg  <= str_pkg::RST_SLOPE_V;
            decay_reg    <= str_pkg::RST_DECAY;
            baseline_reg <= str_pkg::RST_BASELINE;
            vesicle_reg  <= str_pkg::RST_VESICLE;
            refract_reg  <= str_pkg::RST_REFRACT;
        end else if (cfg_we) begin
            case (cfg_index)
                str_pkg::CFG_MODE:     mode_reg     <= cfg_data[0];
                str_pkg::CFG_PEAK:     peak_reg     <= cfg_data[23:0];
                str_pkg::CFG_HALF_V:   half_v_reg   <= cfg_data[str_pkg::VOLT_W-1:0];
                str_pkg::CFG_SLOPE_V:  slope_v_reg  <= cfg_data[str_pkg::SLOPE_W-1:0];
                str_pkg::CFG_DECAY:    decay_reg    <= cfg_data[str_pkg::FACTOR_W-1:0];
                str_pkg::CFG_BASELINE: baseline_reg <= cfg_data[23:0];
                str_pkg::CFG_VESICLE:  vesicle_reg  <= cfg_data[23:0];
                str_pkg::CFG_REFRACT:  refract_reg  <= cfg_data[str_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            conc_reg    <= clamp24(str_pkg::RST_BASELINE);
            armed_reg   <= 1'b0;
            tsr_reg     <= TICK_SAT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                // Release disarms and restarts the refractory count
                armed_reg <= rel_now ? 1'b0 : (armed_reg || v_neg);
                tsr_reg   <= rel_now ? '0 : tsr_inc;
            end
            if (fin_fire) begin
                conc_reg    <= conc_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rel_reg      <= rel_now;
            sig_path_reg <= sig_need;
            down_reg     <= conc_reg > base_c;
            op_a_reg     <= mag;
            op_b_reg     <= EW'(decay_reg);
        end
        if (state_reg == ST_TAB) begin
            op_a_reg <= peak_c;
            op_b_reg <= sig_table[div_idx];
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PW'(op_a_reg) * PW'(op_b_reg);
        end
        if (fin_fire) begin
            m_conc_reg <= (conc_wide > OUT_MAX_W) ? '1 : conc_wide[str_pkg::OUT_CONC_W-1:0];
            m_rel_reg  <= rel_reg;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_concentration = m_conc_reg;
    assign m_released      = m_rel_reg;

    a_div_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("table index arrived outside the divide wait");

    a_release_on_sigmoid: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && rel_reg) |-> sig_path_reg)
        else $error("release finished without a logistic lookup");

    a_release_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && rel_reg) |=> (tsr_reg == '0) && !armed_reg)
        else $error("release left refractory state behind");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid_reg && !m_ready) |=> (state_reg == ST_FIN))
        else $error("finished word dropped while the output stalls");

endmodule

/* rtl/str_idx_div.sv */
// Bit-per-cycle divider that turns a voltage difference into a logistic table index.
`timescale 1ns / 1ps

module str_idx_div #(
    parameter int TABLE_ENTRIES = str_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [str_pkg::VOLT_W:0]  diff,
    input  logic [str_pkg::SLOPE_W-1:0]      slope,
    output logic                             done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);

    localparam int IDXW  = $clog2(TABLE_ENTRIES);
    localparam int MAGW  = str_pkg::VOLT_W + IDXW;
    localparam int DENW  = str_pkg::SLOPE_W + 4;
    localparam int CNTW  = $clog2(IDXW);
    localparam logic [IDXW:0]   HALF   = (IDXW+1)'(TABLE_ENTRIES / 2);
    localparam logic [IDXW-1:0] TOP    = IDXW'(TABLE_ENTRIES - 1);
    localparam logic [CNTW-1:0] LAST   = CNTW'(IDXW - 1);

    logic                  busy_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [DENW-1:0]       rem_reg;
    logic [IDXW-1:0]       lo_reg;
    logic [IDXW-1:0]       q_reg;
    logic [DENW-1:0]       den_reg;
    logic                  sat_reg;
    logic                  neg_reg;
    logic [IDXW-1:0]       idx_reg;

    logic [str_pkg::VOLT_W-1:0]  abs_diff;
    logic [MAGW-1:0]             num_mag;
    logic [str_pkg::VOLT_W-1:0]  rem_init;
    logic [DENW-1:0]             den_init;
    logic [DENW:0]               trial;
    logic                        trial_ge;
    logic [IDXW:0]               q_up;
    logic [IDXW-1:0]             idx_next;

    assign abs_diff = diff[str_pkg::VOLT_W] ? str_pkg::VOLT_W'(-diff)
                                            : str_pkg::VOLT_W'(diff);
    assign num_mag  = MAGW'(abs_diff) * MAGW'(TABLE_ENTRIES);
    assign rem_init = num_mag[MAGW-1:IDXW];
    assign den_init = {(slope == '0) ? str_pkg::SLOPE_W'(1) : slope, 4'b0000};

    assign trial    = {rem_reg, lo_reg[IDXW-1]};
    assign trial_ge = trial >= (DENW+1)'(den_reg);

    // Negative side rounds toward minus infinity: take the ceiling of the magnitude
    assign q_up = (IDXW+1)'(q_reg) + (IDXW+1)'(rem_reg != '0);

    always_comb begin
        if (!neg_reg) begin
            if (sat_reg || ((IDXW+1)'(q_reg) >= HALF)) begin
                idx_next = TOP;
            end else begin
                idx_next = IDXW'((IDXW+1)'(q_reg) + HALF);
            end
        end else begin
            if (sat_reg || (q_up > HALF)) begin
                idx_next = '0;
            end else begin
                idx_next = IDXW'(HALF - q_up);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // Quotient must fit in IDXW bits, else the index saturates
            rem_reg <= DENW'(rem_init);
            lo_reg  <= num_mag[IDXW-1:0];
            q_reg   <= '0;
            den_reg <= den_init;
            sat_reg <= DENW'(rem_init) >= den_init;
            neg_reg <= diff[str_pkg::VOLT_W];
        end else if (busy_reg) begin
            rem_reg <= trial_ge ? DENW'(trial - (DENW+1)'(den_reg)) : DENW'(trial);
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[IDXW-2:0], trial_ge};
        end
        if (fin_reg) begin
            idx_reg <= idx_next;
        end
    end

    assign done = done_reg;
    assign idx  = idx_reg;

    a_done_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(fin_reg))
        else $error("index ready without a finished division");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg && !fin_reg)
        else $error("division restarted while in progress");

    a_fixed_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == LAST && !start) |=> fin_reg)
        else $error("division did not end after its last step");

endmodule

/* tb/transmitter_checker.sv */
// Release checker: watches register writes and both channels, predicts each tick, compares.
`timescale 1ns / 1ps

module transmitter_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [str_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [str_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [str_pkg::VOLT_W-1:0] s_voltage,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [str_pkg::OUT_CONC_W-1:0]    m_concentration,
    input  logic                              m_released,
    output int                                fail_count,
    output int                                outstanding
);

    localparam int LUT_N = str_pkg::DEF_TABLE_ENTRIES;
    localparam longint unsigned ONE_Q32 = 64'd1 << 32;
    localparam logic [23:0] CONC_CEIL = 24'hFFFFFF;

    typedef struct packed {
        logic [23:0] conc;
        logic        released;
    } tick_out_t;

    logic [16:0] lut [LUT_N];

    // register copy
    logic                              mode_r;
    logic [23:0]                       peak_r;
    logic signed [str_pkg::VOLT_W-1:0] half_r;
    logic [str_pkg::SLOPE_W-1:0]       slope_r;
    logic [str_pkg::FACTOR_W-1:0]      decay_r;
    logic [23:0]                       base_r;
    logic [23:0]                       vesicle_r;
    logic [str_pkg::TICK_W-1:0]        refract_r;

    // synapse state
    logic [23:0]                conc_now;
    logic                       armed;
    logic [str_pkg::TICK_W-1:0] since_release;

    tick_out_t tick_q[$];
    int        mismatches = 0;

    assign fail_count = mismatches;

    // e^(-256*r) in Q32 by a short series followed by repeated squaring
    function automatic longint unsigned exp_falloff(input longint unsigned r);
        longint unsigned acc;
        longint unsigned term;
        longint unsigned n;
        acc  = ONE_Q32;
        term = ONE_Q32;
        for (n = 1; n <= 6; n++) begin
            term = ((term * r) >> 32) / n;
            if (n[0]) acc = acc - term;
            else      acc = acc + term;
        end
        for (n = 0; n < 8; n++)
            acc = (acc * acc + (64'd1 << 31)) >> 32;
        return acc;
    endfunction

    initial begin
        longint          c;
        longint unsigned m;
        longint unsigned d;
        longint unsigned s;
        for (int i = 0; i < LUT_N; i++) begin
            c = 2 * i - LUT_N + 1;
            m = (c < 0) ? -c : c;
            d = ONE_Q32 + exp_falloff((m << 27) / LUT_N);
            s = ((64'd1 << 48) + d / 2) / d;
            if (c < 0) s = 65536 - s;
            lut[i] = s[16:0];
        end
    end

    function automatic logic [23:0] logistic_conc(input logic signed [str_pkg::VOLT_W-1:0] v);
        longint          diff;
        longint          den;
        longint          num;
        longint          q;
        longint          idx;
        longint unsigned prod;
        diff = longint'(v) - longint'(half_r);
        den  = (slope_r == '0) ? 16 : 16 * longint'(slope_r);
        num  = diff * LUT_N;
        // floor division toward minus infinity
        if (num >= 0) q = num / den;
        else          q = -((-num + den - 1) / den);
        idx = q + LUT_N / 2;
        if (idx < 0) idx = 0;
        if (idx > LUT_N - 1) idx = LUT_N - 1;
        prod = (64'(peak_r) * 64'(lut[int'(idx)]) + 64'd32768) >> 16;
        if (prod > 64'(CONC_CEIL)) prod = 64'(CONC_CEIL);
        return prod[23:0];
    endfunction

    function automatic tick_out_t predict_tick(input logic signed [str_pkg::VOLT_W-1:0] v);
        tick_out_t       res;
        logic [23:0]     gap;
        longint unsigned stepv;
        logic [24:0]     sum;
        res.released = 1'b0;
        if (since_release != '1) since_release = since_release + 1'b1;
        if (v < 0) armed = 1'b1;

        if (mode_r == str_pkg::MODE_SIGMOID) begin
            conc_now = logistic_conc(v);
        end else begin
            gap   = (conc_now > base_r) ? conc_now - base_r : base_r - conc_now;
            stepv = (64'(decay_r) * 64'(gap) + 64'd32768) >> 16;
            if (conc_now > base_r) conc_now = conc_now - stepv[23:0];
            else                   conc_now = conc_now + stepv[23:0];
        end

        if (v > 0 && armed && since_release >= refract_r) begin
            res.released  = 1'b1;
            armed         = 1'b0;
            since_release = '0;
            conc_now      = logistic_conc(v);
            if (mode_r != str_pkg::MODE_SIGMOID) begin
                sum      = {1'b0, conc_now} + {1'b0, vesicle_r};
                conc_now = sum[24] ? CONC_CEIL : sum[23:0];
            end
        end
        res.conc = conc_now;
        return res;
    endfunction

    always @(posedge aclk) begin
        tick_out_t want;
        if (!aresetn) begin
            mode_r        = str_pkg::RST_MODE;
            peak_r        = str_pkg::RST_PEAK;
            half_r        = str_pkg::RST_HALF_V;
            slope_r       = str_pkg::RST_SLOPE_V;
            decay_r       = str_pkg::RST_DECAY;
            base_r        = str_pkg::RST_BASELINE;
            vesicle_r     = str_pkg::RST_VESICLE;
            refract_r     = str_pkg::RST_REFRACT;
            conc_now      = str_pkg::RST_BASELINE;
            armed         = 1'b0;
            since_release = '1;
            tick_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    str_pkg::CFG_MODE:     mode_r    = cfg_data[0];
                    str_pkg::CFG_PEAK:     peak_r    = cfg_data[23:0];
                    str_pkg::CFG_HALF_V:   half_r    = cfg_data[str_pkg::VOLT_W-1:0];
                    str_pkg::CFG_SLOPE_V:  slope_r   = cfg_data[str_pkg::SLOPE_W-1:0];
                    str_pkg::CFG_DECAY:    decay_r   = cfg_data[str_pkg::FACTOR_W-1:0];
                    str_pkg::CFG_BASELINE: base_r    = cfg_data[23:0];
                    str_pkg::CFG_VESICLE:  vesicle_r = cfg_data[23:0];
                    str_pkg::CFG_REFRACT:  refract_r = cfg_data[str_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            // retire before predicting so an unexpected word is never matched to a new tick
            if (m_valid && m_ready) begin
                if (tick_q.size() == 0) begin
                    $error("result word with nothing expected: concentration %h released %b",
                           m_concentration, m_released);
                    mismatches++;
                end else begin
                    want = tick_q.pop_front();
                    if (m_concentration !== want.conc) begin
                        $error("concentration: expected %h, got %h", want.conc, m_concentration);
                        mismatches++;
                    end
                    if (m_released !== want.released) begin
                        $error("released: expected %b, got %b", want.released, m_released);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) tick_q.insert(tick_q.size(), predict_tick(s_voltage));
        end
        outstanding <= tick_q.size();
    end

endmodule

/* tb/tb.sv */
// Transmitter release testbench top: clock, reset, register writes, voltage words, verdict.
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 165;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [str_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [str_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [str_pkg::VOLT_W-1:0] s_voltage = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [str_pkg::OUT_CONC_W-1:0]    m_concentration;
    logic                              m_released;

    int fail_count;
    int outstanding;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_req      = 1'b0;

    always #6 aclk = ~aclk;

    synaptic_transmitter_release dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_voltage       (s_voltage),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_concentration (m_concentration),
        .m_released      (m_released)
    );

    transmitter_checker release_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_voltage       (s_voltage),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_concentration (m_concentration),
        .m_released      (m_released),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // receiver: random backpressure, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog: end the run when no word moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_voltage(input logic signed [str_pkg::VOLT_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_voltage <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [str_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic mode, input logic [23:0] peak,
                             input logic [15:0] half, input logic [14:0] slope,
                             input logic [15:0] decay, input logic [23:0] base,
                             input logic [23:0] vesicle, input logic [15:0] refract);
        write_reg(str_pkg::CFG_MODE, {23'd0, mode});
        write_reg(str_pkg::CFG_PEAK, peak);
        write_reg(str_pkg::CFG_HALF_V, {8'd0, half});
        write_reg(str_pkg::CFG_SLOPE_V, {9'd0, slope});
        write_reg(str_pkg::CFG_DECAY, {8'd0, decay});
        write_reg(str_pkg::CFG_BASELINE, base);
        write_reg(str_pkg::CFG_VESICLE, vesicle);
        write_reg(str_pkg::CFG_REFRACT, {8'd0, refract});
        end_writes();
    endtask

    initial begin
        logic                              mode_v;
        logic [23:0]                       peak_v;
        logic [15:0]                       half_v;
        logic [14:0]                       slope_v;
        logic [15:0]                       decay_v;
        logic [23:0]                       base_v;
        logic [23:0]                       vesicle_v;
        logic [15:0]                       refract_v;
        logic signed [str_pkg::VOLT_W-1:0] v;
        bit                                go_up;
        int                                r;
        int                                span;
        int                                mag;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults, decay mode: arm, release, zero neither arms nor releases
        send_voltage(-16'sd256);  send_voltage(16'sd256);  send_voltage(16'sd0);
        send_voltage(16'sd512);   send_voltage(-16'sd32768); send_voltage(16'sd32767);
        send_voltage(-16'sd1);    send_voltage(16'sd1);    send_voltage(16'sd0);
        drain();

        // sigmoid with zero slope, which counts as one
        load_regs(str_pkg::MODE_SIGMOID, 24'hFFFFFF, 16'h0000, 15'd0, 16'd655, 24'd0, 24'd0,
                  16'd0);
        send_voltage(-16'sd32768); send_voltage(16'sd32767); send_voltage(-16'sd1);
        send_voltage(16'sd1);      send_voltage(16'sd0);
        drain();

        load_regs(str_pkg::MODE_SIGMOID, 24'd0, 16'h8000, 15'h7FFF, 16'd0, 24'd0, 24'd0,
                  16'd0);
        send_voltage(16'sd32767);  send_voltage(-16'sd32768);
        drain();

        // decay mode pinned at the top: release saturates with the full vesicle
        load_regs(~str_pkg::MODE_SIGMOID, 24'hFFFFFF, 16'h0000, 15'd256, 16'hFFFF, 24'hFFFFFF,
                  24'hFFFFFF, 16'd0);
        send_voltage(-16'sd1); send_voltage(16'sd1); send_voltage(-16'sd1);
        send_voltage(16'sd200);
        drain();

        // longest refractory period blocks the next release
        write_reg(str_pkg::CFG_REFRACT, 24'h00FFFF);
        end_writes();
        send_voltage(-16'sd1); send_voltage(16'sd1);
        drain();

        // baseline moved with no decay: concentration must hold
        write_reg(str_pkg::CFG_DECAY, 24'd0);
        write_reg(str_pkg::CFG_BASELINE, 24'd0);
        end_writes();
        send_voltage(16'sd0); send_voltage(16'sd0);
        drain();

        go_up = 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                src_idle_pct  = 11;
                sink_idle_pct = 77;
            end else if (p < 4) begin
                src_idle_pct  = 77;
                sink_idle_pct = 11;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            mode_v    = p[0];
            peak_v    = (p == 4) ? 24'hFFFFFF : 24'($urandom);
            half_v    = (p == 3) ? 16'h7FFF : 16'($urandom_range(4095) - 2048);
            slope_v   = (p == 2) ? 15'h7FFF : (p == 5) ? 15'd0 : 15'($urandom_range(1, 2048));
            decay_v   = (p == 1) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom);
            base_v    = 24'($urandom);
            vesicle_v = (p == 5) ? 24'hFFFFFF : 24'($urandom);
            refract_v = (p == 3) ? 16'hFFFF : 16'($urandom_range(12));
            load_regs(mode_v, peak_v, half_v, slope_v, decay_v, base_v, vesicle_v, refract_v);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == 40) hold_req = 1'b1;
                if (p == 4 && n == 80) drain();
                // runs of negative then positive voltages arm and release
                if ($urandom_range(3) == 0) go_up = !go_up;
                r = $urandom_range(99);
                if (r < 10) begin
                    v = 16'($urandom);
                end else if (r < 15) begin
                    v = '0;
                end else begin
                    span = 8 * int'(slope_v) + 1;
                    if (span > 32767) span = 32767;
                    mag = $urandom_range(1, span);
                    v   = go_up ? 16'(mag) : -16'(mag);
                end
                send_voltage(v);
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* synaptic_transmitter_release.f */
rtl/str_pkg.sv
rtl/str_idx_div.sv
rtl/synaptic_transmitter_release.sv
tb/transmitter_checker.sv
tb/tb.sv
